>>> hw/rtl/cache_way_replacement_policy_top_defines.svh
// Assertion macros shared by the replacement policy modules.
`ifndef CACHE_WAY_REPLACEMENT_POLICY_TOP_DEFINES_SVH
`define CACHE_WAY_REPLACEMENT_POLICY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CWRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CWRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cwrp_pkg.sv
// Types, constants and codes shared by the replacement policy modules.
package cwrp_pkg;

	// Geometry
	localparam int SETS   = 64;
	localparam int WAYS   = 8;
	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TREE_N = 2 ** WAY_W;
	localparam int AGE_W  = 31;

	// Field widths fixed by the interface
	localparam int SETIDX_W = 6;
	localparam int HITWAY_W = 3;
	localparam int VICT_W   = 3;
	localparam int NWAYS_W  = 4;
	localparam int POL_W    = 2;

	// Age constants
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
	localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};

	// Policy codes
	localparam logic [POL_W-1:0] POL_LRU   = 2'd0;
	localparam logic [POL_W-1:0] POL_FIFO  = 2'd1;
	localparam logic [POL_W-1:0] POL_AGING = 2'd2;
	localparam logic [POL_W-1:0] POL_RSVD  = 2'd3;

	// Command codes
	localparam logic CMD_HIT     = 1'b0;
	localparam logic CMD_REPLACE = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'b1;
	localparam logic [NWAYS_W-1:0]   WAYS_RESET      = NWAYS_W'(WAYS);

	// Request transaction
	typedef struct packed {
		logic                command;
		logic [SETIDX_W-1:0] set_index;
		logic [HITWAY_W-1:0] hit_way;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic [VICT_W-1:0] victim_way;
		logic              was_empty;
	} rsp_t;

	// One set row of the state memory
	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0][AGE_W-1:0] age;
	} row_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_replace;
	} dp_sts_t;

endpackage

>>> hw/rtl/cache_way_replacement_policy_top.sv
// Top level of the per-set cache way replacement block.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  req     | in        | req_valid / req_stall  | command, set_index, hit_way
//  rsp     | out       | rsp_valid / rsp_stall  | victim_way, was_empty
//  cfg     | in        | cfg_wr_en              | cfg_index, cfg_data
//
// A transaction reads the set row from the single-port row memory, then searches,
// updates and writes it back; the next is taken right after.
// Reset clears the row live bits at once; no clearing pass, no startup delay.
// A replace waits in the update cycle while an earlier result sits stalled;
// a hit never waits on rsp_stall.
module cache_way_replacement_policy_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  cwrp_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output cwrp_pkg::rsp_t                  rsp,
	input  logic                            cfg_wr_en,
	input  logic [cwrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cwrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	cwrp_pkg::ctrl_cmd_t cmd;
	cwrp_pkg::dp_sts_t   sts;

	// Sequence transactions
	cwrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold state and compute victims
	cwrp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

>>> hw/rtl/cwrp_datapath.sv
// Datapath: config registers, set-row memory, victim search, age update, result register.
`include "cache_way_replacement_policy_top_defines.svh"

module cwrp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cwrp_pkg::req_t                      req,
	input  logic                                cfg_wr_en,
	input  logic [cwrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cwrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  cwrp_pkg::ctrl_cmd_t                 cmd,
	output cwrp_pkg::dp_sts_t                   sts,
	output cwrp_pkg::rsp_t                      rsp
);

	// Configuration registers
	logic [cwrp_pkg::POL_W-1:0]   policy_q;
	logic [cwrp_pkg::NWAYS_W-1:0] ways_q;

	// Set-row memory and per-row live bits
	cwrp_pkg::row_t mem_q [cwrp_pkg::SETS];
	logic [cwrp_pkg::SETS-1:0] row_live_q;

	// Item held across the read
	logic                          cmd_s1;
	logic [cwrp_pkg::SET_W-1:0]    set_s1;
	logic [cwrp_pkg::HITWAY_W-1:0] hit_s1;
	cwrp_pkg::row_t                rd_row_s1;
	logic                          live_s1;

	cwrp_pkg::rsp_t rsp_q;

	// Decoded control and computed row
	logic [cwrp_pkg::POL_W-1:0]   mode;
	logic [cwrp_pkg::NWAYS_W-1:0] n_eff;
	logic [cwrp_pkg::WAYS-1:0]    in_use;
	logic [cwrp_pkg::WAYS-1:0]    eff_valid;
	logic [cwrp_pkg::WAYS-1:0]    empty;
	logic                         found;
	logic [cwrp_pkg::WAY_W-1:0]   first_empty;
	logic [cwrp_pkg::WAY_W-1:0]   best;
	logic [cwrp_pkg::WAY_W-1:0]   victim;
	logic                         hit_ok;
	cwrp_pkg::row_t               new_row;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= cwrp_pkg::POL_LRU;
			ways_q   <= cwrp_pkg::WAYS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cwrp_pkg::CFG_POLICY_MODE: policy_q <= cfg_data[cwrp_pkg::POL_W-1:0];
				cwrp_pkg::CFG_WAYS_IN_USE: ways_q   <= cfg_data[cwrp_pkg::NWAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the transaction and read its set row
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1    <= req.command;
			set_s1    <= req.set_index[cwrp_pkg::SET_W-1:0];
			hit_s1    <= req.hit_way;
			rd_row_s1 <= mem_q[req.set_index[cwrp_pkg::SET_W-1:0]];
		end
		if (cmd.commit) begin
			mem_q[set_s1] <= new_row;
		end
	end

	// Track rows written since reset; sample the live bit with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_live_q <= '0;
			live_s1    <= 1'b0;
		end else begin
			if (cmd.load) begin
				live_s1 <= row_live_q[req.set_index[cwrp_pkg::SET_W-1:0]];
			end
			if (cmd.commit) begin
				row_live_q[set_s1] <= 1'b1;
			end
		end
	end

	// Decode policy and clamp the way count
	always_comb begin
		mode = (policy_q == cwrp_pkg::POL_RSVD) ? cwrp_pkg::POL_LRU : policy_q;
		if (ways_q == '0) begin
			n_eff = cwrp_pkg::NWAYS_W'(1);
		end else if (ways_q > cwrp_pkg::WAYS_RESET) begin
			n_eff = cwrp_pkg::WAYS_RESET;
		end else begin
			n_eff = ways_q;
		end
		for (int w = 0; w < cwrp_pkg::WAYS; w++) begin
			in_use[w] = (cwrp_pkg::NWAYS_W'(w) < n_eff);
		end
		eff_valid = live_s1 ? rd_row_s1.valid : '0;
		empty     = in_use & ~eff_valid;
		found     = |empty;
		hit_ok    = ({1'b0, hit_s1} < n_eff) && eff_valid[hit_s1[cwrp_pkg::WAY_W-1:0]];
	end

	// Find the lowest empty way
	always_comb begin
		first_empty = '0;
		for (int w = cwrp_pkg::WAYS - 1; w >= 0; w--) begin
			if (empty[w]) begin
				first_empty = cwrp_pkg::WAY_W'(w);
			end
		end
	end

	// Compare tree: oldest with ties low, or smallest aging value with ties high
	always_comb begin
		logic                         t_en  [cwrp_pkg::WAY_W+1][cwrp_pkg::TREE_N];
		logic [cwrp_pkg::AGE_W-1:0]   t_age [cwrp_pkg::WAY_W+1][cwrp_pkg::TREE_N];
		logic [cwrp_pkg::WAY_W-1:0]   t_idx [cwrp_pkg::WAY_W+1][cwrp_pkg::TREE_N];
		logic                         take_hi;
		for (int l = 0; l <= cwrp_pkg::WAY_W; l++) begin
			for (int i = 0; i < cwrp_pkg::TREE_N; i++) begin
				t_en[l][i]  = 1'b0;
				t_age[l][i] = '0;
				t_idx[l][i] = '0;
			end
		end
		for (int w = 0; w < cwrp_pkg::WAYS; w++) begin
			t_en[0][w]  = in_use[w];
			t_age[0][w] = rd_row_s1.age[w];
			t_idx[0][w] = cwrp_pkg::WAY_W'(w);
		end
		for (int l = 1; l <= cwrp_pkg::WAY_W; l++) begin
			for (int i = 0; i < cwrp_pkg::TREE_N / 2; i++) begin
				if (mode == cwrp_pkg::POL_AGING) begin
					take_hi = t_en[l-1][2*i+1] && (!t_en[l-1][2*i] ||
						(t_age[l-1][2*i+1] <= t_age[l-1][2*i]));
				end else begin
					take_hi = t_en[l-1][2*i+1] && (!t_en[l-1][2*i] ||
						(t_age[l-1][2*i+1] > t_age[l-1][2*i]));
				end
				t_en[l][i]  = t_en[l-1][2*i] | t_en[l-1][2*i+1];
				t_age[l][i] = take_hi ? t_age[l-1][2*i+1] : t_age[l-1][2*i];
				t_idx[l][i] = take_hi ? t_idx[l-1][2*i+1] : t_idx[l-1][2*i];
			end
		end
		best = t_idx[cwrp_pkg::WAY_W][0];
	end

	// Age the set, then mark the victim, or the hit way under LRU or aging
	always_comb begin
		logic [cwrp_pkg::AGE_W-1:0] aged;
		victim  = found ? first_empty : best;
		new_row = rd_row_s1;
		new_row.valid = eff_valid;
		aged = '0;
		if (cmd_s1 == cwrp_pkg::CMD_REPLACE || hit_ok) begin
			for (int w = 0; w < cwrp_pkg::WAYS; w++) begin
				if (in_use[w] && eff_valid[w]) begin
					if (mode == cwrp_pkg::POL_AGING) begin
						new_row.age[w] = rd_row_s1.age[w] >> 1;
					end else if (rd_row_s1.age[w] != cwrp_pkg::AGE_MAX) begin
						new_row.age[w] = rd_row_s1.age[w] + cwrp_pkg::AGE_W'(1);
					end
				end
			end
		end
		if (cmd_s1 == cwrp_pkg::CMD_REPLACE) begin
			aged = found ? '0 : new_row.age[victim];
			if (mode == cwrp_pkg::POL_AGING) begin
				new_row.age[victim] = aged | cwrp_pkg::AGE_TOP;
			end else begin
				new_row.age[victim] = '0;
			end
			new_row.valid[victim] = 1'b1;
		end else if (hit_ok) begin
			if (mode == cwrp_pkg::POL_LRU) begin
				new_row.age[hit_s1[cwrp_pkg::WAY_W-1:0]] = '0;
			end else if (mode == cwrp_pkg::POL_AGING) begin
				new_row.age[hit_s1[cwrp_pkg::WAY_W-1:0]] =
					new_row.age[hit_s1[cwrp_pkg::WAY_W-1:0]] | cwrp_pkg::AGE_TOP;
			end
		end
	end

	// Load the result register on a replace
	always_ff @(posedge clk) begin
		if (cmd.commit && cmd_s1 == cwrp_pkg::CMD_REPLACE) begin
			rsp_q.victim_way <= cwrp_pkg::VICT_W'(victim);
			rsp_q.was_empty  <= found;
		end
	end

	assign sts.is_replace = (cmd_s1 == cwrp_pkg::CMD_REPLACE);
	assign rsp            = rsp_q;

	// Ages of empty ways are never written, so compare them bit for bit, unknowns included
	`CWRP_ASSERT_NOW(a_victim_in_use, cmd.commit && cmd_s1 == cwrp_pkg::CMD_REPLACE, {1'b0, victim} < n_eff, "victim outside the ways in use")
	`CWRP_ASSERT_NOW(a_ignored_hit_keeps_row, cmd.commit && cmd_s1 == cwrp_pkg::CMD_HIT && !hit_ok, new_row.age === rd_row_s1.age && new_row.valid === eff_valid, "ignored hit changed the set row")
	`CWRP_ASSERT_NEXT(a_row_live_after_commit, cmd.commit, row_live_q[$past(set_s1)], "written row not marked live")

endmodule

>>> hw/rtl/cwrp_ctrl.sv
// Controller: accept, read-then-commit sequencing, result valid tracking.
`include "cache_way_replacement_policy_top_defines.svh"

module cwrp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  cwrp_pkg::dp_sts_t   sts,
	output cwrp_pkg::ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Result slot can take a new transaction this cycle
	assign out_free = !out_valid_q || !rsp_stall;

	// Issue load in idle, commit once the result slot has room
	assign cmd.load   = (state_q == ST_IDLE) && req_valid;
	assign cmd.commit = (state_q == ST_EXEC) && (!sts.is_replace || out_free);

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (req_valid) begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: if (cmd.commit) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit && sts.is_replace) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	`CWRP_ASSERT_NOW(a_no_overwrite, cmd.commit && sts.is_replace, !(out_valid_q && rsp_stall), "pending result overwritten")
	`CWRP_ASSERT_NEXT(a_commit_frees, cmd.commit, state_q == ST_IDLE && (!$past(sts.is_replace) || out_valid_q), "commit did not finish the transaction")
	`CWRP_ASSERT_NEXT(a_load_starts, cmd.load, state_q == ST_EXEC && req_stall, "accepted transaction not in progress")

endmodule
